// ----- rtl/srl_pkg.sv -----
// Shared types, constants and character helpers for the S-record loader.
package srl_pkg;

    localparam int ADDRESS_BITS = 24;
    localparam int CHAR_W       = 8;
    localparam int WR_ADDR_W    = 24;
    localparam int BYTE_W       = 8;

    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    // Address bytes in the header of each record type
    localparam logic [1:0] HDR_S1 = 2'd2;
    localparam logic [1:0] HDR_S2 = 2'd3;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_GOT_S,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_S1,
        KIND_S2
    } t_kind;

    typedef struct packed {
        logic                 valid;
        logic [WR_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]    data;
    } t_write;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Non-hex characters decode as zero
    function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

endpackage

// ----- rtl/srl_parser.sv -----
// Record parser: token state machine, hex pairing and address generation.
module srl_parser import srl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CHAR_W-1:0] i_character,
    output t_write            o_write
);

    t_phase                  r_phase,     n_phase;
    t_kind                   r_kind,      n_kind;
    logic [1:0]              r_hdr_left,  n_hdr_left;
    logic [7:0]              r_data_left, n_data_left;
    logic [ADDRESS_BITS-1:0] r_load_addr, n_load_addr;
    logic [3:0]              r_high_nib,  n_high_nib;
    logic                    r_pending,   n_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_kind      <= KIND_NONE;
            r_hdr_left  <= '0;
            r_data_left <= '0;
            r_load_addr <= '0;
            r_high_nib  <= '0;
            r_pending   <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_hdr_left  <= n_hdr_left;
            r_data_left <= n_data_left;
            r_load_addr <= n_load_addr;
            r_high_nib  <= n_high_nib;
            r_pending   <= n_pending;
        end
    end

    always_comb begin
        logic [BYTE_W-1:0] v_byte;
        logic [1:0]        v_hdr;
        logic [1:0]        v_hdr_dec;
        logic [31:0]       v_addr_ext;

        n_phase     = r_phase;
        n_kind      = r_kind;
        n_hdr_left  = r_hdr_left;
        n_data_left = r_data_left;
        n_load_addr = r_load_addr;
        n_high_nib  = r_high_nib;
        n_pending   = r_pending;

        v_byte     = {r_high_nib, hex_value(i_character)};
        v_hdr      = (r_kind == KIND_S2) ? HDR_S2 : HDR_S1;
        v_hdr_dec  = r_hdr_left - 2'd1;
        v_addr_ext = 32'(r_load_addr);

        o_write.valid = 1'b0;
        o_write.addr  = v_addr_ext[WR_ADDR_W-1:0];
        o_write.data  = v_byte;

        if (is_blank(i_character)) begin
            n_phase    = PH_WAIT;
            n_pending  = 1'b0;
            n_high_nib = '0;
        end else begin
            case (r_phase)
                PH_WAIT: begin
                    n_kind  = KIND_NONE;
                    n_phase = (i_character == CH_S) ? PH_GOT_S : PH_SKIP;
                end
                PH_GOT_S: begin
                    n_pending = 1'b0;
                    if (i_character == CH_ONE) begin
                        n_kind  = KIND_S1;
                        n_phase = PH_COUNT;
                    end else if (i_character == CH_TWO) begin
                        n_kind  = KIND_S2;
                        n_phase = PH_COUNT;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_COUNT, PH_ADDR, PH_DATA: begin
                    if (!r_pending) begin
                        n_high_nib = hex_value(i_character);
                        n_pending  = 1'b1;
                    end else begin
                        n_pending  = 1'b0;
                        n_high_nib = '0;
                        if (r_phase == PH_COUNT) begin
                            // count covers address, data and checksum bytes
                            if (v_byte < {6'd0, v_hdr} + 8'd1) begin
                                n_data_left = '0;
                                n_hdr_left  = '0;
                                n_phase     = PH_SKIP;
                            end else begin
                                n_data_left = v_byte - {6'd0, v_hdr} - 8'd1;
                                n_hdr_left  = v_hdr;
                                n_load_addr = '0;
                                n_phase     = PH_ADDR;
                            end
                        end else if (r_phase == PH_ADDR) begin
                            n_load_addr = {r_load_addr[ADDRESS_BITS-BYTE_W-1:0], v_byte};
                            n_hdr_left  = v_hdr_dec;
                            if (v_hdr_dec == 2'd0) begin
                                n_phase = (r_data_left == 8'd0) ? PH_SKIP : PH_DATA;
                            end
                        end else begin
                            o_write.valid = 1'b1;
                            n_load_addr   = r_load_addr + ADDRESS_BITS'(1);
                            n_data_left   = r_data_left - 8'd1;
                            if (r_data_left == 8'd1) begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_SKIP;
                end
            endcase
        end
    end

endmodule

// ----- rtl/srecord_loader_unit.sv -----
// Top level of the streaming S1/S2 record loader with registered write output.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_character
//   output   out        o_valid / i_stall    o_write_address, o_write_data
//
// One character per cycle while not stalled; a write appears in the cycle after
// the character that completes its data byte. The parser state and a single output
// register are the only storage. Reset is synchronous and returns the parser to
// waiting for a token. The input stalls only while a write is held and the
// output stalls; a held write is taken and refilled in the same cycle.
module srecord_loader_unit import srl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CHAR_W-1:0]    i_character,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WR_ADDR_W-1:0] o_write_address,
    output logic [BYTE_W-1:0]    o_write_data
);

    logic                 w_in_accept;
    t_write               w_write;
    logic                 r_out_valid;
    logic [WR_ADDR_W-1:0] r_out_addr;
    logic [BYTE_W-1:0]    r_out_data;

    assign o_stall     = r_out_valid && i_stall;
    assign w_in_accept = i_valid && !o_stall;

    srl_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_accept),
        .i_character (i_character),
        .o_write     (w_write)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_stall) begin
            r_out_valid <= w_in_accept && w_write.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_write.valid) begin
            r_out_addr <= w_write.addr;
            r_out_data <= w_write.data;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_write_address = r_out_addr;
    assign o_write_data    = r_out_data;

`ifndef SYNTHESIS
    // a held write is never overwritten by a new transaction
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !w_in_accept)
        else $error("input accepted while output write held");

    // whitespace never yields a write
    a_blank_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && ((i_character == CH_SPACE) || (i_character == CH_TAB) ||
                         (i_character == CH_CR) || (i_character == CH_LF)))
        |=> !o_valid || $past(o_stall))
        else $error("write produced by whitespace");

    // an accepted write-producing transaction shows up at the output next cycle
    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_write.valid) |=> (o_valid && o_write_data == $past(w_write.data)))
        else $error("decoded write lost");
`endif

endmodule
